// ----- rtl/pgf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgf_pkg
// Shared formats, widths and payload types of the pairwise gravity force
// pipeline.
// ----------------------------------------------------------------------------
package pgf_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FORCE_BITS = 48;

    // displacement magnitude, mass product, squared distance
    localparam int MAG_W    = COORD_BITS + 1;
    localparam int MM_W     = 2 * COORD_BITS;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int R2_W     = SQ_W + 2;
    // radicand r2 * 2^(2F) and its root
    localparam int T_W      = R2_W + 2 * FRAC_BITS;
    localparam int SQ_STEPS = T_W / 2;
    localparam int ROOT_W   = SQ_STEPS;
    localparam int SREM_W   = ROOT_W + 3;
    // numerator |d| * Mt * Ms, its partial products, denominator r2 * root
    localparam int PART_W   = MAG_W + COORD_BITS;
    localparam int NUM_W    = MAG_W + MM_W;
    localparam int DEN_W    = R2_W + ROOT_W;
    localparam int NP_W     = NUM_W + 2 * FRAC_BITS;
    localparam int TOP_W    = NP_W - FORCE_BITS;
    localparam int DREM_W   = DEN_W + 1;
    // split of the denominator product into narrow multipliers
    localparam int R2_LO_W  = R2_W / 2;
    localparam int R2_HI_W  = R2_W - R2_LO_W;
    localparam int RT_LO_W  = ROOT_W / 2;
    localparam int RT_HI_W  = ROOT_W - RT_LO_W;

    typedef logic [MAG_W-1:0]      mag_t;
    typedef logic [SQ_W-1:0]       sq_t;
    typedef logic [R2_W-1:0]       r2_t;
    typedef logic [T_W-1:0]        tv_t;
    typedef logic [ROOT_W-1:0]     root_t;
    typedef logic [SREM_W-1:0]     srem_t;
    typedef logic [PART_W-1:0]     part_t;
    typedef logic [NUM_W-1:0]      num_t;
    typedef logic [DEN_W-1:0]      den_t;
    typedef logic [DREM_W-1:0]     drem_t;
    typedef logic [FORCE_BITS-1:0] force_t;

    typedef struct packed {
        logic        [COORD_BITS-1:0] target_mass;
        logic signed [COORD_BITS-1:0] target_x;
        logic signed [COORD_BITS-1:0] target_y;
        logic signed [COORD_BITS-1:0] target_z;
        logic        [COORD_BITS-1:0] source_mass;
        logic signed [COORD_BITS-1:0] source_x;
        logic signed [COORD_BITS-1:0] source_y;
        logic signed [COORD_BITS-1:0] source_z;
    } in_t;

    typedef struct packed {
        logic signed [FORCE_BITS-1:0] force_x;
        logic signed [FORCE_BITS-1:0] force_y;
        logic signed [FORCE_BITS-1:0] force_z;
        logic                         coincident;
        logic                         saturated;
    } out_t;

    // travels alongside the root pipeline
    typedef struct packed {
        r2_t             r2;
        logic [2:0][NUM_W-1:0] num;
        logic [2:0]      neg;
        logic            coinc;
    } sqrt_side_t;

    // travels alongside one divider lane
    typedef struct packed {
        logic neg;
        logic coinc;
    } div_side_t;

endpackage

// ----- rtl/pgf_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgf_isqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module pgf_isqrt (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  pgf_pkg::tv_t           radicand,
    input  pgf_pkg::sqrt_side_t    side_in,
    output logic                   out_valid,
    output pgf_pkg::root_t         root,
    output pgf_pkg::sqrt_side_t    side_out
);

    logic                v_reg    [pgf_pkg::SQ_STEPS];
    pgf_pkg::srem_t      rem_reg  [pgf_pkg::SQ_STEPS];
    pgf_pkg::root_t      root_reg [pgf_pkg::SQ_STEPS];
    pgf_pkg::tv_t        t_reg    [pgf_pkg::SQ_STEPS];
    pgf_pkg::sqrt_side_t side_reg [pgf_pkg::SQ_STEPS];

    for (genvar k = 0; k < pgf_pkg::SQ_STEPS; k++) begin : g_step
        logic                v_in;
        pgf_pkg::srem_t      rem_in, rem_sh, trial, rem_next;
        pgf_pkg::root_t      root_in, root_next;
        pgf_pkg::tv_t        t_in;
        pgf_pkg::sqrt_side_t side_in_k;
        logic                ge;

        if (k == 0) begin : g_first
            assign v_in      = in_valid;
            assign rem_in    = '0;
            assign root_in   = '0;
            assign t_in      = radicand;
            assign side_in_k = side_in;
        end else begin : g_next
            assign v_in      = v_reg[k-1];
            assign rem_in    = rem_reg[k-1];
            assign root_in   = root_reg[k-1];
            assign t_in      = t_reg[k-1];
            assign side_in_k = side_reg[k-1];
        end

        // bring down the next pair of radicand bits and try root*4+1
        assign rem_sh    = {rem_in[pgf_pkg::SREM_W-3:0], t_in[pgf_pkg::T_W-1 -: 2]};
        assign trial     = pgf_pkg::srem_t'({root_in, 2'b01});
        assign ge        = (rem_sh >= trial);
        assign rem_next  = ge ? (rem_sh - trial) : rem_sh;
        assign root_next = {root_in[pgf_pkg::ROOT_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                t_reg[k]    <= t_in << 2;
                side_reg[k] <= side_in_k;
            end
        end
    end

    assign out_valid = v_reg[pgf_pkg::SQ_STEPS-1];
    assign root      = root_reg[pgf_pkg::SQ_STEPS-1];
    assign side_out  = side_reg[pgf_pkg::SQ_STEPS-1];

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(out_valid))
        else $error("root pipeline valid moved during stall");

    a_root_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en && out_valid) |=> $stable(root) && $stable(side_out))
        else $error("root pipeline payload moved during stall");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (rem_reg[pgf_pkg::SQ_STEPS-1] <= {root, 1'b0}))
        else $error("root remainder exceeds twice the root");

endmodule

// ----- rtl/pgf_div_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgf_div_lane
// Pipelined restoring divider for one force component: quotient of
// num * 2^(2F) by den: overflow flag stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module pgf_div_lane (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  pgf_pkg::num_t        num,
    input  pgf_pkg::den_t        den,
    input  pgf_pkg::div_side_t   side_in,
    output logic                 out_valid,
    output pgf_pkg::force_t      quot,
    output logic                 big,
    output pgf_pkg::div_side_t   side_out
);

    localparam int NST = pgf_pkg::FORCE_BITS + 1;

    logic                v_reg    [NST];
    pgf_pkg::drem_t      rem_reg  [NST];
    pgf_pkg::den_t       den_reg  [NST];
    pgf_pkg::force_t     nlo_reg  [NST];
    pgf_pkg::force_t     q_reg    [NST];
    logic                big_reg  [NST];
    pgf_pkg::div_side_t  side_reg [NST];

    logic [pgf_pkg::NP_W-1:0] np;
    assign np = {num, {(2 * pgf_pkg::FRAC_BITS){1'b0}}};

    for (genvar k = 0; k < NST; k++) begin : g_step
        logic               v_in;
        pgf_pkg::drem_t     rem_next;
        pgf_pkg::den_t      den_next;
        pgf_pkg::force_t    nlo_next, q_next;
        logic               big_next;
        pgf_pkg::div_side_t side_next;

        if (k == 0) begin : g_first
            logic [pgf_pkg::TOP_W-1:0] top;
            // quotient fits the force width only if the top part is below den
            assign top       = np[pgf_pkg::NP_W-1:pgf_pkg::FORCE_BITS];
            assign v_in      = in_valid;
            assign rem_next  = pgf_pkg::drem_t'(top);
            assign den_next  = den;
            assign nlo_next  = np[pgf_pkg::FORCE_BITS-1:0];
            assign q_next    = '0;
            assign big_next  = (pgf_pkg::drem_t'(top) >= pgf_pkg::drem_t'(den));
            assign side_next = side_in;
        end else begin : g_next
            pgf_pkg::drem_t rem_sh, den_ext;
            logic           ge;
            assign rem_sh    = {rem_reg[k-1][pgf_pkg::DREM_W-2:0],
                                nlo_reg[k-1][pgf_pkg::FORCE_BITS-1]};
            assign den_ext   = pgf_pkg::drem_t'(den_reg[k-1]);
            assign ge        = (rem_sh >= den_ext);
            assign v_in      = v_reg[k-1];
            assign rem_next  = ge ? (rem_sh - den_ext) : rem_sh;
            assign den_next  = den_reg[k-1];
            assign nlo_next  = nlo_reg[k-1] << 1;
            assign q_next    = {q_reg[k-1][pgf_pkg::FORCE_BITS-2:0], ge};
            assign big_next  = big_reg[k-1];
            assign side_next = side_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_next;
                nlo_reg[k]  <= nlo_next;
                q_reg[k]    <= q_next;
                big_reg[k]  <= big_next;
                side_reg[k] <= side_next;
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign quot      = q_reg[NST-1];
    assign big       = big_reg[NST-1];
    assign side_out  = side_reg[NST-1];

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(out_valid))
        else $error("divider valid moved during stall");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !big && !side_out.coinc) |->
            (rem_reg[NST-1] < pgf_pkg::drem_t'(den_reg[NST-1])))
        else $error("divider remainder not below divisor");

    a_q_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en && out_valid) |=> $stable(quot) && $stable(big))
        else $error("divider payload moved during stall");

endmodule

// ----- rtl/pairwise_gravity_force_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_gravity_force_top
// Pairwise Newtonian force d * Mt * Ms / r^3 in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Takes a body pair per clock and returns a force per clock unless stalled.
// Input passes four front stages (displacement, magnitude, squares and mass
// products, sums), a 50-stage square root that resolves one root bit per
// stage, three stages forming r^2 * r, a 49-stage restoring divider per
// component that checks overflow, then resolves one quotient bit per later
// stage, and the output register. A two-entry output buffer lets the
// pipeline keep accepting while a result waits; once both entries hold
// results, s_ready drops and the whole pipeline holds until m_ready returns.
module pairwise_gravity_force_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pgf_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output pgf_pkg::out_t m_data
);

    localparam int CB = pgf_pkg::COORD_BITS;

    logic en;
    logic skid_full_reg, out_v_reg;
    pgf_pkg::out_t skid_reg, out_reg;

    // ---------------- front stages
    logic                         s1_v_reg;
    logic signed [pgf_pkg::MAG_W-1:0] s1_d_reg [3];
    logic [pgf_pkg::MM_W-1:0]     s1_mm_reg;

    logic                         s2_v_reg, s2_coinc_reg;
    pgf_pkg::mag_t                s2_mag_reg [3];
    logic [2:0]                   s2_neg_reg;
    logic [pgf_pkg::MM_W-1:0]     s2_mm_reg;

    logic                         s3_v_reg, s3_coinc_reg;
    pgf_pkg::sq_t                 s3_sq_reg  [3];
    pgf_pkg::part_t               s3_plo_reg [3];
    pgf_pkg::part_t               s3_phi_reg [3];
    logic [2:0]                   s3_neg_reg;

    logic                         s4_v_reg;
    pgf_pkg::sqrt_side_t          s4_side_reg;

    logic signed [pgf_pkg::MAG_W-1:0] s1_d_next [3];
    logic signed [CB-1:0]         src_c [3];
    logic signed [CB-1:0]         tgt_c [3];

    assign src_c[0] = s_data.source_x;
    assign src_c[1] = s_data.source_y;
    assign src_c[2] = s_data.source_z;
    assign tgt_c[0] = s_data.target_x;
    assign tgt_c[1] = s_data.target_y;
    assign tgt_c[2] = s_data.target_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s1_d_next[i] = $signed({src_c[i][CB-1], src_c[i]})
                         - $signed({tgt_c[i][CB-1], tgt_c[i]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg <= s_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s1_d_reg[i] <= s1_d_next[i];
                s2_neg_reg[i] <= s1_d_reg[i][pgf_pkg::MAG_W-1];
                s2_mag_reg[i] <= s1_d_reg[i][pgf_pkg::MAG_W-1] ? pgf_pkg::mag_t'(-s1_d_reg[i])
                                                             : pgf_pkg::mag_t'(s1_d_reg[i]);
                s3_sq_reg[i]  <= pgf_pkg::sq_t'(s2_mag_reg[i]) * pgf_pkg::sq_t'(s2_mag_reg[i]);
                s3_plo_reg[i] <= pgf_pkg::part_t'(s2_mag_reg[i])
                               * pgf_pkg::part_t'(s2_mm_reg[CB-1:0]);
                s3_phi_reg[i] <= pgf_pkg::part_t'(s2_mag_reg[i])
                               * pgf_pkg::part_t'(s2_mm_reg[pgf_pkg::MM_W-1:CB]);
                s4_side_reg.num[i] <= pgf_pkg::num_t'(s3_plo_reg[i])
                                    + (pgf_pkg::num_t'(s3_phi_reg[i]) << CB);
            end
            s1_mm_reg <= pgf_pkg::MM_W'(s_data.target_mass) * pgf_pkg::MM_W'(s_data.source_mass);
            s2_mm_reg <= s1_mm_reg;
            s2_coinc_reg <= (s1_d_reg[0] == '0) && (s1_d_reg[1] == '0) && (s1_d_reg[2] == '0);
            s3_neg_reg   <= s2_neg_reg;
            s3_coinc_reg <= s2_coinc_reg;
            s4_side_reg.r2 <= pgf_pkg::r2_t'(s3_sq_reg[0]) + pgf_pkg::r2_t'(s3_sq_reg[1])
                            + pgf_pkg::r2_t'(s3_sq_reg[2]);
            s4_side_reg.neg   <= s3_neg_reg;
            s4_side_reg.coinc <= s3_coinc_reg;
        end
    end

    // ---------------- square root of r2 * 2^(2F)
    logic                sq_v;
    pgf_pkg::root_t      sq_root;
    pgf_pkg::sqrt_side_t sq_side;

    pgf_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s4_v_reg),
        .radicand  ({s4_side_reg.r2, {(2 * pgf_pkg::FRAC_BITS){1'b0}}}),
        .side_in   (s4_side_reg),
        .out_valid (sq_v),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // ---------------- denominator r2 * root over three stages
    localparam int PLL_W = pgf_pkg::R2_LO_W + pgf_pkg::RT_LO_W;
    localparam int PLH_W = pgf_pkg::R2_LO_W + pgf_pkg::RT_HI_W;
    localparam int PHL_W = pgf_pkg::R2_HI_W + pgf_pkg::RT_LO_W;
    localparam int PHH_W = pgf_pkg::R2_HI_W + pgf_pkg::RT_HI_W;

    logic                  d1_v_reg, d2_v_reg, d3_v_reg;
    logic [PLL_W-1:0]      d1_pll_reg;
    logic [PLH_W-1:0]      d1_plh_reg;
    logic [PHL_W-1:0]      d1_phl_reg;
    logic [PHH_W-1:0]      d1_phh_reg;
    pgf_pkg::den_t         d2_a_reg, d2_b_reg, d3_den_reg;
    pgf_pkg::num_t         d1_num_reg [3];
    pgf_pkg::num_t         d2_num_reg [3];
    pgf_pkg::num_t         d3_num_reg [3];
    logic [2:0]            d1_neg_reg, d2_neg_reg, d3_neg_reg;
    logic                  d1_coinc_reg, d2_coinc_reg, d3_coinc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_v_reg <= 1'b0;
            d2_v_reg <= 1'b0;
            d3_v_reg <= 1'b0;
        end else if (en) begin
            d1_v_reg <= sq_v;
            d2_v_reg <= d1_v_reg;
            d3_v_reg <= d2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_pll_reg <= PLL_W'(sq_side.r2[pgf_pkg::R2_LO_W-1:0])
                        * PLL_W'(sq_root[pgf_pkg::RT_LO_W-1:0]);
            d1_plh_reg <= PLH_W'(sq_side.r2[pgf_pkg::R2_LO_W-1:0])
                        * PLH_W'(sq_root[pgf_pkg::ROOT_W-1:pgf_pkg::RT_LO_W]);
            d1_phl_reg <= PHL_W'(sq_side.r2[pgf_pkg::R2_W-1:pgf_pkg::R2_LO_W])
                        * PHL_W'(sq_root[pgf_pkg::RT_LO_W-1:0]);
            d1_phh_reg <= PHH_W'(sq_side.r2[pgf_pkg::R2_W-1:pgf_pkg::R2_LO_W])
                        * PHH_W'(sq_root[pgf_pkg::ROOT_W-1:pgf_pkg::RT_LO_W]);
            // low and high partial products do not overlap: place side by side
            d2_a_reg   <= {d1_phh_reg, d1_pll_reg};
            d2_b_reg   <= (pgf_pkg::den_t'(d1_plh_reg) << pgf_pkg::RT_LO_W)
                        + (pgf_pkg::den_t'(d1_phl_reg) << pgf_pkg::R2_LO_W);
            d3_den_reg <= d2_a_reg + d2_b_reg;
            for (int i = 0; i < 3; i++) begin
                d1_num_reg[i] <= sq_side.num[i];
                d2_num_reg[i] <= d1_num_reg[i];
                d3_num_reg[i] <= d2_num_reg[i];
            end
            d1_neg_reg   <= sq_side.neg;
            d2_neg_reg   <= d1_neg_reg;
            d3_neg_reg   <= d2_neg_reg;
            d1_coinc_reg <= sq_side.coinc;
            d2_coinc_reg <= d1_coinc_reg;
            d3_coinc_reg <= d2_coinc_reg;
        end
    end

    // ---------------- per-component dividers
    logic               dv_v    [3];
    pgf_pkg::force_t    dv_q    [3];
    logic               dv_big  [3];
    pgf_pkg::div_side_t dv_side [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        pgf_div_lane u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (d3_v_reg),
            .num       (d3_num_reg[i]),
            .den       (d3_den_reg),
            .side_in   ({d3_neg_reg[i], d3_coinc_reg}),
            .out_valid (dv_v[i]),
            .quot      (dv_q[i]),
            .big       (dv_big[i]),
            .side_out  (dv_side[i])
        );
    end

    // ---------------- saturate, apply sign, flag coincident bodies
    pgf_pkg::force_t lim   [3];
    pgf_pkg::force_t mag_f [3];
    pgf_pkg::force_t frc   [3];
    logic [2:0]      sat;
    logic            coinc;
    pgf_pkg::out_t   res_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lim[i]   = dv_side[i].neg ? (pgf_pkg::force_t'(1) << (pgf_pkg::FORCE_BITS - 1))
                     : ((pgf_pkg::force_t'(1) << (pgf_pkg::FORCE_BITS - 1))
                        - pgf_pkg::force_t'(1));
            sat[i]   = dv_big[i] || (dv_q[i] > lim[i]);
            mag_f[i] = sat[i] ? lim[i] : dv_q[i];
            frc[i]   = dv_side[i].neg ? -mag_f[i] : mag_f[i];
        end
        coinc = dv_side[0].coinc;
        res_next.force_x    = coinc ? '0 : frc[0];
        res_next.force_y    = coinc ? '0 : frc[1];
        res_next.force_z    = coinc ? '0 : frc[2];
        res_next.coincident = coinc;
        res_next.saturated  = !coinc && (sat != 3'b000);
    end

    // ---------------- output register plus one spare entry
    assign en      = !skid_full_reg;
    assign s_ready = en;
    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg     <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (!out_v_reg || m_ready) begin
            if (skid_full_reg) begin
                out_v_reg     <= 1'b1;
                out_reg       <= skid_reg;
                skid_full_reg <= 1'b0;
            end else begin
                out_v_reg <= dv_v[0];
                out_reg   <= res_next;
            end
        end else if (dv_v[0] && !skid_full_reg) begin
            // hold the arriving result while the output waits
            skid_full_reg <= 1'b1;
            skid_reg      <= res_next;
        end
    end

    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_v[0] == dv_v[1]) && (dv_v[0] == dv_v[2]))
        else $error("divider lanes out of step");

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> out_v_reg)
        else $error("spare entry full while output empty");

    a_coinc_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.coincident) |->
            (m_data.force_x == '0) && (m_data.force_y == '0) &&
            (m_data.force_z == '0) && !m_data.saturated)
        else $error("coincident result carries a force");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_v_reg && !m_ready && dv_v[0] && !skid_full_reg) |=> skid_full_reg)
        else $error("arriving result dropped while output stalled");

endmodule
